// File: design/sled_pkg.sv
// shared types and constants for the sysex led command decoder
package sled_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] BYTE_START  = 8'hF0;
	localparam logic [7:0] BYTE_END    = 8'hF7;
	localparam logic [7:0] CMD_PACKED  = 8'h5F;
	localparam logic [7:0] CMD_LIGHT   = 8'h6F;
	localparam logic [7:0] CMD_FLASH   = 8'h6B;
	localparam logic [7:0] CMD_PULSE   = 8'h6C;
	localparam logic [7:0] CODE_SINGLE_MAX = 8'd99;
	localparam logic [7:0] CODE_ROW_MIN    = 8'd100;
	localparam logic [7:0] CODE_ROW_MAX    = 8'd109;
	localparam logic [7:0] CODE_COL_MAX    = 8'd119;

	localparam logic [1:0] ACT_LIGHT = 2'd0;
	localparam logic [1:0] ACT_FLASH = 2'd1;
	localparam logic [1:0] ACT_PULSE = 2'd2;

	localparam logic [2:0] LAST_STEP = 3'd7;

	localparam logic [2:0] REG_LISTEN_PORT  = 3'd0;
	localparam logic [2:0] REG_LEDS_ENABLED = 3'd4;

	typedef enum logic [6:0] {
		PH_IDLE  = 7'b0000001,
		PH_CMD   = 7'b0000010,
		PH_SKIP  = 7'b0000100,
		PH_COLOR = 7'b0001000,
		PH_COUNT = 7'b0010000,
		PH_PITCH = 7'b0100000,
		PH_GROUP = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		JOB_SINGLE = 2'd0,
		JOB_BCAST  = 2'd1,
		JOB_ROW    = 2'd2,
		JOB_COL    = 2'd3
	} job_mode_t;

	typedef struct packed {
		job_mode_t  mode;
		logic [1:0] action;
		logic [6:0] pitch;
		logic [6:0] red;
		logic [6:0] green;
		logic [6:0] blue;
	} job_t;

endpackage

// File: design/sysex_led_command_decoder_core.sv
// top level of the sysex led command decoder: config registers, parser, queue, expander
//
//  channel | direction | handshake            | word
//  in      | input     | in_valid / in_stall  | port, data_byte
//  out     | output    | out_valid / out_stall| action, broadcast, pitch, red, green, blue, last
//  apb     | input     | psel / penable       | port select at 0x0, leds_enabled at 0x4
//
// the parser takes one byte per cycle while the job queue has room
// the expander sends one write per cycle unless out_stall holds it
// a row or column code expands into eight writes, set by the expander step counter
// in_stall rises only when the job queue is full; out_stall freezes a valid output register
// reset clears parser state, queue pointers and output valid; registers return to defaults
module sysex_led_command_decoder_core #(
	parameter int unsigned QueueDepth = sled_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  port,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic        broadcast,
	output logic [6:0]  pitch,
	output logic [6:0]  red,
	output logic [6:0]  green,
	output logic [6:0]  blue,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sled_pkg::*;

	logic       rd_sel_port;
	logic [1:0] port_reg_q;
	logic       leds_en_q;
	logic       cfg_wr;
	logic       q_push;
	logic       q_ready;
	logic       q_head_valid;
	logic       q_pop;
	job_t       push_job;
	job_t       head_job;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_reg_q <= 2'd0;
			leds_en_q  <= 1'b1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_LEDS_ENABLED[2]) begin
				leds_en_q <= pwdata[0];
			end else begin
				port_reg_q <= pwdata[1:0];
			end
		end
	end

	assign rd_sel_port = (paddr[2] == REG_LISTEN_PORT[2]);
	assign prdata = rd_sel_port ? {30'd0, port_reg_q} : {31'd0, leds_en_q};

	assign in_stall = !q_ready;

	sled_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_take    (in_valid && q_ready),
		.port         (port),
		.data_byte    (data_byte),
		.listen_port  (port_reg_q),
		.leds_enabled (leds_en_q),
		.job_push     (q_push),
		.job          (push_job)
	);

	sled_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_job   (push_job),
		.pop        (q_pop),
		.ready      (q_ready),
		.head_valid (q_head_valid),
		.head_job   (head_job)
	);

	sled_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head_job   (head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.broadcast  (broadcast),
		.pitch      (pitch),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last       (last)
	);

endmodule

// File: design/sled_front.sv
// byte parser: tracks the sysex message and turns led groups into write jobs
module sled_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_take,
	input  logic [1:0]       port,
	input  logic [7:0]       data_byte,
	input  logic [1:0]       listen_port,
	input  logic             leds_enabled,
	output logic             job_push,
	output sled_pkg::job_t   job
);
	import sled_pkg::*;

	phase_t     phase_q;
	logic [1:0] kind_q;
	logic [1:0] pos_q;
	logic [6:0] red_q;
	logic [6:0] green_q;
	logic [6:0] blue_q;
	logic [6:0] pitch_q;
	logic [6:0] left_q;

	logic [6:0] v;
	logic [7:0] code_off;
	logic [3:0] row_idx;
	logic [2:0] flags;
	logic       ctl_byte;
	logic       job_en;

	assign v        = data_byte[6:0];
	assign code_off = data_byte - CODE_ROW_MIN;
	assign row_idx  = code_off[3:0];
	assign flags    = {red_q[6], green_q[6], v[6]};
	assign ctl_byte = (data_byte == BYTE_START) || (data_byte == BYTE_END);

	always_comb begin
		job_en     = 1'b0;
		job.mode   = JOB_SINGLE;
		job.action = ACT_LIGHT;
		job.pitch  = v;
		job.red    = red_q;
		job.green  = green_q;
		job.blue   = blue_q;
		if (!ctl_byte && phase_q == PH_PITCH) begin
			if (data_byte == 8'd0) begin
				job_en    = 1'b1;
				job.mode  = JOB_BCAST;
				job.pitch = 7'd0;
			end else if (data_byte <= CODE_SINGLE_MAX) begin
				job_en = 1'b1;
			end else if (data_byte <= CODE_ROW_MAX) begin
				job_en    = 1'b1;
				job.mode  = JOB_ROW;
				job.pitch = {row_idx, 3'b000} + {2'b00, row_idx, 1'b0} + 7'd1;
			end else if (data_byte <= CODE_COL_MAX) begin
				job_en    = 1'b1;
				job.mode  = JOB_COL;
				job.pitch = code_off[6:0];
			end
		end else if (!ctl_byte && phase_q == PH_GROUP && pos_q == 2'd3) begin
			job_en     = 1'b1;
			job.action = kind_q;
			job.pitch  = pitch_q;
			job.blue   = v;
		end
	end

	assign job_push = byte_take && job_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			kind_q  <= ACT_LIGHT;
			pos_q   <= 2'd0;
			red_q   <= 7'd0;
			green_q <= 7'd0;
			blue_q  <= 7'd0;
			pitch_q <= 7'd0;
			left_q  <= 7'd0;
		end else if (byte_take) begin
			if (data_byte == BYTE_START) begin
				phase_q <= PH_CMD;
				pos_q   <= 2'd0;
				left_q  <= 7'd0;
			end else if (data_byte == BYTE_END) begin
				phase_q <= PH_IDLE;
				pos_q   <= 2'd0;
				left_q  <= 7'd0;
			end else begin
				unique case (phase_q)
					PH_CMD: begin
						pos_q <= 2'd0;
						if (port != listen_port || !leds_enabled) begin
							phase_q <= PH_SKIP;
						end else if (data_byte == CMD_PACKED) begin
							phase_q <= PH_COLOR;
						end else if (data_byte == CMD_LIGHT) begin
							kind_q  <= ACT_LIGHT;
							phase_q <= PH_GROUP;
						end else if (data_byte == CMD_FLASH) begin
							kind_q  <= ACT_FLASH;
							phase_q <= PH_GROUP;
						end else if (data_byte == CMD_PULSE) begin
							kind_q  <= ACT_PULSE;
							phase_q <= PH_GROUP;
						end else begin
							phase_q <= PH_SKIP;
						end
					end
					PH_COLOR: begin
						if (pos_q == 2'd0) begin
							red_q <= v;
							pos_q <= 2'd1;
						end else if (pos_q == 2'd1) begin
							green_q <= v;
							pos_q   <= 2'd2;
						end else begin
							red_q   <= {1'b0, red_q[5:0]};
							green_q <= {1'b0, green_q[5:0]};
							blue_q  <= {1'b0, v[5:0]};
							pos_q   <= 2'd0;
							if (flags != 3'd0) begin
								left_q  <= {4'd0, flags};
								phase_q <= PH_PITCH;
							end else begin
								phase_q <= PH_COUNT;
							end
						end
					end
					PH_COUNT: begin
						if (v == 7'd0) begin
							phase_q <= PH_COLOR;
						end else begin
							left_q  <= v;
							phase_q <= PH_PITCH;
						end
					end
					PH_PITCH: begin
						left_q <= left_q - 7'd1;
						if (left_q == 7'd1) begin
							phase_q <= PH_COLOR;
						end
					end
					PH_GROUP: begin
						unique case (pos_q)
							2'd0: pitch_q <= v;
							2'd1: red_q   <= v;
							2'd2: green_q <= v;
							default: blue_q <= v;
						endcase
						pos_q <= pos_q + 2'd1;
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
		end
	end

endmodule

// File: design/sled_queue.sv
// short job queue between the parser and the write expander
module sled_queue #(
	parameter int unsigned Depth = sled_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sled_pkg::job_t      push_job,
	input  logic                pop,
	output logic                ready,
	output logic                head_valid,
	output sled_pkg::job_t      head_job
);
	import sled_pkg::*;

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	job_t            slot_q [Depth];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] cnt_q;

	assign ready      = (cnt_q != CntW'(Depth));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: design/sled_back.sv
// write expander: steps through each job and drives the output register
module sled_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  sled_pkg::job_t   head_job,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       action,
	output logic             broadcast,
	output logic [6:0]       pitch,
	output logic [6:0]       red,
	output logic [6:0]       green,
	output logic [6:0]       blue,
	output logic             last
);
	import sled_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [1:0] action_q;
	logic       bcast_q;
	logic [6:0] pitch_q;
	logic [6:0] red_q;
	logic [6:0] green_q;
	logic [6:0] blue_q;
	logic       last_q;

	logic       advance;
	logic       last_w;
	logic [6:0] pitch_w;

	assign advance = !out_valid_q || !out_stall;

	always_comb begin
		unique case (head_job.mode)
			JOB_ROW: begin
				pitch_w = head_job.pitch + {4'd0, step_q};
				last_w  = (step_q == LAST_STEP);
			end
			JOB_COL: begin
				pitch_w = head_job.pitch + {1'b0, step_q, 3'b000} + {3'b000, step_q, 1'b0};
				last_w  = (step_q == LAST_STEP);
			end
			default: begin
				pitch_w = head_job.pitch;
				last_w  = 1'b1;
			end
		endcase
	end

	assign pop = advance && head_valid && last_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				step_q <= last_w ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && head_valid) begin
			action_q <= head_job.action;
			bcast_q  <= (head_job.mode == JOB_BCAST);
			pitch_q  <= pitch_w;
			red_q    <= head_job.red;
			green_q  <= head_job.green;
			blue_q   <= head_job.blue;
			last_q   <= last_w;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign broadcast = bcast_q;
	assign pitch     = pitch_q;
	assign red       = red_q;
	assign green     = green_q;
	assign blue      = blue_q;
	assign last      = last_q;

endmodule

// File: verif/sysex_led_command_decoder_core_test.sv
// self-checking testbench for the sysex led command decoder core
module sysex_led_command_decoder_core_test;
	import sled_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned PHASE_WORDS   = 40;
	localparam int unsigned NUM_PHASES    = 5;
	localparam int unsigned COL_END       = 90;
	localparam int unsigned DIRECTED_LEN  = 27;

	typedef struct packed {
		logic [1:0] action;
		logic       broadcast;
		logic [6:0] pitch;
		logic [6:0] red;
		logic [6:0] green;
		logic [6:0] blue;
		logic       last;
	} led_write_t;

	typedef struct packed {
		logic [1:0] prt;
		logic [7:0] b;
	} midi_word_t;

	class led_write_tracker;
		logic [1:0] listen_port = 2'd0;
		logic       leds_on = 1'b1;
		phase_t     ph = PH_IDLE;
		logic [1:0] act = ACT_LIGHT;
		logic [1:0] pos = 2'd0;
		logic [6:0] red_hold = 7'd0;
		logic [6:0] green_hold = 7'd0;
		logic [6:0] blue_hold = 7'd0;
		logic [6:0] pitch_hold = 7'd0;
		logic [6:0] left = 7'd0;
		led_write_t expected_writes[$];
		int unsigned errors = 0;

		function led_write_t write_of(logic [1:0] a, logic bc, logic [6:0] p);
			led_write_t w;
			w.action = a;
			w.broadcast = bc;
			w.pitch = p;
			w.red = red_hold;
			w.green = green_hold;
			w.blue = blue_hold;
			w.last = 1'b0;
			return w;
		endfunction

		function void take_byte(logic [1:0] prt, logic [7:0] d);
			led_write_t w[$];
			led_write_t tail;
			logic [6:0] v;
			logic [2:0] n;
			int unsigned q;
			v = d[6:0];
			if (d == BYTE_START || d == BYTE_END) begin
				ph = (d == BYTE_START) ? PH_CMD : PH_IDLE;
				pos = 2'd0;
				left = 7'd0;
				return;
			end
			case (ph)
				PH_CMD: begin
					pos = 2'd0;
					if (prt != listen_port || !leds_on) begin
						ph = PH_SKIP;
					end else if (d == CMD_PACKED) begin
						ph = PH_COLOR;
					end else if (d == CMD_LIGHT) begin
						act = ACT_LIGHT;
						ph = PH_GROUP;
					end else if (d == CMD_FLASH) begin
						act = ACT_FLASH;
						ph = PH_GROUP;
					end else if (d == CMD_PULSE) begin
						act = ACT_PULSE;
						ph = PH_GROUP;
					end else begin
						ph = PH_SKIP;
					end
				end
				PH_COLOR: begin
					case (pos)
						2'd0: begin
							red_hold = v;
							pos = 2'd1;
						end
						2'd1: begin
							green_hold = v;
							pos = 2'd2;
						end
						default: begin
							blue_hold = v;
							n = {red_hold[6], green_hold[6], blue_hold[6]};
							red_hold[6] = 1'b0;
							green_hold[6] = 1'b0;
							blue_hold[6] = 1'b0;
							pos = 2'd0;
							if (n != 3'd0) begin
								left = 7'(n);
								ph = PH_PITCH;
							end else begin
								ph = PH_COUNT;
							end
						end
					endcase
				end
				PH_COUNT: begin
					if (v == 7'd0) begin
						ph = PH_COLOR;
					end else begin
						left = v;
						ph = PH_PITCH;
					end
				end
				PH_PITCH: begin
					if (d == 8'd0) begin
						w.push_back(write_of(ACT_LIGHT, 1'b1, 7'd0));
					end else if (d <= CODE_SINGLE_MAX) begin
						w.push_back(write_of(ACT_LIGHT, 1'b0, d[6:0]));
					end else if (d <= CODE_ROW_MAX) begin
						q = (d - CODE_ROW_MIN) * 10 + 1;
						for (int i = 0; i < 8; i++)
							w.push_back(write_of(ACT_LIGHT, 1'b0, 7'(q + i)));
					end else if (d <= CODE_COL_MAX) begin
						for (q = d - CODE_ROW_MIN; q < COL_END; q += 10)
							w.push_back(write_of(ACT_LIGHT, 1'b0, 7'(q)));
					end
					left = left - 7'd1;
					if (left == 7'd0)
						ph = PH_COLOR;
				end
				PH_GROUP: begin
					case (pos)
						2'd0: pitch_hold = v;
						2'd1: red_hold = v;
						2'd2: green_hold = v;
						default: begin
							blue_hold = v;
							w.push_back(write_of(act, 1'b0, pitch_hold));
						end
					endcase
					pos = pos + 2'd1;
				end
				default: ;
			endcase
			if (w.size() != 0) begin
				tail = w.pop_back();
				tail.last = 1'b1;
				w.push_back(tail);
			end
			foreach (w[i])
				expected_writes.push_back(w[i]);
		endfunction

		task report(string what);
			$display("write mismatch: %s", what);
			errors++;
		endtask

		task compare(string field, logic [6:0] got, logic [6:0] want);
			if (got !== want)
				report($sformatf("%s got %0h want %0h", field, got, want));
		endtask

		task check_write(led_write_t got);
			led_write_t want;
			if (expected_writes.size() == 0) begin
				report($sformatf("unexpected word, pitch %0d", got.pitch));
				return;
			end
			want = expected_writes.pop_front();
			compare("action", got.action, want.action);
			compare("broadcast", got.broadcast, want.broadcast);
			compare("pitch", got.pitch, want.pitch);
			compare("red", got.red, want.red);
			compare("green", got.green, want.green);
			compare("blue", got.blue, want.blue);
			compare("last", got.last, want.last);
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  port = 2'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  action;
	logic        broadcast;
	logic [6:0]  pitch;
	logic [6:0]  red;
	logic [6:0]  green;
	logic [6:0]  blue;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	led_write_tracker tracker = new();
	midi_word_t  stim[$];
	logic        tx_gaps = 1'b1;
	logic        rx_stalls = 1'b1;
	logic        hold_req = 1'b0;
	int unsigned hold_count = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;

	logic [1:0] phase_port [NUM_PHASES] = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd3};
	logic       phase_en [NUM_PHASES]   = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
	logic [7:0] directed_bytes [DIRECTED_LEN] = '{
		BYTE_START, CMD_PACKED, 8'h7F, 8'h7F, 8'h7F, 8'd0, 8'd99, 8'd100, 8'd109,
		8'd110, 8'd119, 8'd120, 8'h00, 8'h00, 8'h00, 8'h00, BYTE_END,
		BYTE_START, CMD_FLASH, 8'hFF, 8'h80, 8'h7F, 8'h01,
		BYTE_START, CMD_PULSE, 8'h02, BYTE_END
	};

	sysex_led_command_decoder_core dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** sysex_led_command_decoder_core: FAILED **");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [1:0] rand_port();
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic logic [7:0] any_data();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while (b == BYTE_START || b == BYTE_END);
		return b;
	endfunction

	function automatic logic [7:0] pitch_code();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = 8'd0;
			1, 2, 3: b = 8'($urandom_range(1, CODE_SINGLE_MAX));
			4, 5: b = 8'($urandom_range(CODE_ROW_MIN, CODE_ROW_MAX));
			6, 7: b = 8'($urandom_range(CODE_ROW_MAX + 1, CODE_COL_MAX));
			default: begin
				do
					b = any_data();
				while (b <= CODE_COL_MAX);
			end
		endcase
		return b;
	endfunction

	function automatic void push_word(logic [1:0] p, logic [7:0] b);
		stim.push_back({p, b});
	endfunction

	task automatic emit_message();
		logic [7:0] body[$];
		logic [7:0] c0, c1, c2, cmd;
		logic [1:0] prt;
		int unsigned r, n, cut;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			repeat ($urandom_range(1, 6))
				push_word(rand_port(), 8'($urandom_range(0, 255)));
			return;
		end
		prt = (r < 22) ? rand_port() : tracker.listen_port;
		case ($urandom_range(0, 9))
			0: cmd = any_data();
			1, 2, 3, 4: cmd = CMD_PACKED;
			5, 6: cmd = CMD_LIGHT;
			7: cmd = CMD_FLASH;
			default: cmd = CMD_PULSE;
		endcase
		repeat ($urandom_range(1, 3)) begin
			if (cmd == CMD_PACKED) begin
				c0 = any_data();
				c1 = any_data();
				c2 = any_data();
				if ($urandom_range(0, 3) == 0) begin
					c0[6] = 1'b0;
					c1[6] = 1'b0;
					c2[6] = 1'b0;
				end
				body.push_back(c0);
				body.push_back(c1);
				body.push_back(c2);
				n = {c0[6], c1[6], c2[6]};
				if (n == 0) begin
					c0 = {1'($urandom_range(0, 1)), 7'($urandom_range(0, 4))};
					body.push_back(c0);
					n = c0[6:0];
				end
				repeat (n)
					body.push_back(pitch_code());
			end else begin
				repeat (4)
					body.push_back(any_data());
			end
		end
		if ($urandom_range(0, 6) == 0 && body.size() > 1) begin
			cut = $urandom_range(1, body.size() - 1);
			while (body.size() > cut)
				void'(body.pop_back());
		end
		push_word(rand_port(), BYTE_START);
		push_word(prt, cmd);
		foreach (body[i])
			push_word(rand_port(), body[i]);
		if ($urandom_range(0, 19) != 0)
			push_word(rand_port(), BYTE_END);
	endtask

	task automatic send_byte(midi_word_t x);
		int unsigned gap;
		gap = tx_gaps ? pick_gap() : 0;
		repeat (gap) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		port = x.prt;
		data_byte = x.b;
		do
			@(posedge clk);
		while (in_stall);
		tracker.take_byte(x.prt, x.b);
		@(negedge clk);
	endtask

	task automatic send_words(int unsigned count);
		int unsigned k;
		k = count;
		while (k != 0 && stim.size() != 0) begin
			send_byte(stim.pop_front());
			k--;
		end
		in_valid = 1'b0;
	endtask

	task automatic wait_writes_done();
		while (tracker.expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_leds(logic [1:0] p, logic en);
		write_reg(REG_LISTEN_PORT, 32'(p));
		tracker.listen_port = p;
		write_reg(REG_LEDS_ENABLED, 32'(en));
		tracker.leds_on = en;
	endtask

	// output side: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				hold_count++;
				if (hold_count == HOLD_CYCLES) begin
					hold_req = 1'b0;
					hold_count = 0;
				end
			end else if (stall_left != 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else begin
				out_stall = 1'b0;
				if (rx_stalls)
					stall_left = pick_gap();
			end
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall)
				tracker.check_write({action, broadcast, pitch, red, green, blue, last});
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_leds(2'd0, 1'b1);
		for (int i = 0; i < DIRECTED_LEN; i++)
			push_word((i != 0 && directed_bytes[i - 1] == BYTE_START) ? 2'd0 : 2'(i),
				directed_bytes[i]);
		send_words(DIRECTED_LEN);
		wait_writes_done();
		for (int ph_i = 0; ph_i < NUM_PHASES; ph_i++) begin
			set_leds(phase_port[ph_i], phase_en[ph_i]);
			tx_gaps = (ph_i != 0 && ph_i != 3);
			rx_stalls = (ph_i != 3);
			while (stim.size() < PHASE_WORDS)
				emit_message();
			if (ph_i == 0)
				hold_req = 1'b1;
			if (ph_i == 2) begin
				send_words(PHASE_WORDS / 2);
				wait_writes_done();
			end
			send_words(stim.size());
			wait_writes_done();
		end
		if (tracker.errors == 0)
			$display("** sysex_led_command_decoder_core: PASSED **");
		else
			$display("** sysex_led_command_decoder_core: FAILED **");
		$finish;
	end

endmodule
